// ===== rtl/core/mi_pkg.sv =====
`timescale 1ns / 1ps

package mi_pkg;

    // Modulus register width and coefficient width (modulus plus sign)
    localparam int MOD_BITS = 15;
    localparam int COEF_BITS = MOD_BITS + 1;
    localparam logic [MOD_BITS-1:0] MOD_RESET = 15'd2;
    localparam logic [MOD_BITS-1:0] MOD_MIN = 15'd2;

    // Register indexes on the configuration port
    localparam logic REG_MODULUS = 1'b0;

    // Microprogram addresses
    localparam int UA_BITS = 2;
    localparam logic [UA_BITS-1:0] UA_IDLE = 2'd0;
    localparam logic [UA_BITS-1:0] UA_STEP = 2'd1;
    localparam logic [UA_BITS-1:0] UA_DONE = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        C_ALWAYS,
        C_NO_BEAT,
        C_MORE,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [UA_BITS-1:0] jump;
        logic [UA_BITS-1:0] seq;
    } t_uword;

    // Control store: next = cond ? jump : seq
    function automatic t_uword ucode_rom(input logic [UA_BITS-1:0] addr);
        t_uword w;
        case (addr)
            UA_IDLE: w = '{op: OP_LOAD,   cond: C_NO_BEAT,  jump: UA_IDLE, seq: UA_STEP};
            UA_STEP: w = '{op: OP_STEP,   cond: C_MORE,     jump: UA_STEP, seq: UA_DONE};
            UA_DONE: w = '{op: OP_FINISH, cond: C_OUT_FULL, jump: UA_DONE, seq: UA_IDLE};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,   jump: UA_IDLE, seq: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/modular_inverse_unit.sv =====
`timescale 1ns / 1ps

// Modular inverse of a signed operand against the programmed modulus, found
// by extended Euclid driven from a three-word microprogram. An item is loaded,
// run through the shifted-subtract steps of the Euclid loop, and then its result
// is formed: each step takes the largest v*2^k that fits under u, and a large
// operand takes extra steps to reduce. The single shared subtract/compare unit
// serves every step. One item is in flight at a time; a new one is taken while
// the previous result still waits at the output. no_inverse is raised for a zero
// operand, when gcd(|a|, m) > 1, and for a modulus below two.
module modular_inverse_unit #(
    parameter int WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WIDTH-1:0]     i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mi_pkg::MOD_BITS-1:0] o_inverse,
    output logic                        o_no_inverse,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mi_pkg::*;

    localparam int RW = (WIDTH > MOD_BITS) ? WIDTH : MOD_BITS;
    localparam int KW = $clog2(RW);

    logic [MOD_BITS-1:0]  r_mod;
    logic [UA_BITS-1:0]   r_upc, n_upc;
    logic [RW-1:0]        r_ra, r_rb;
    logic [COEF_BITS-1:0] r_ta, r_tb;
    logic                 r_neg;
    logic                 r_out_valid;
    logic [MOD_BITS-1:0]  r_inverse;
    logic                 r_no_inv;

    t_uword uw;
    logic   in_beat, out_full, cond_hit;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODULUS) ? {{(32-MOD_BITS){1'b0}}, r_mod} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODULUS) begin
            r_mod <= pwdata[MOD_BITS-1:0];
        end
    end

    // Handshake
    assign o_stall = (r_upc != UA_IDLE);
    assign in_beat = i_valid && !o_stall;
    assign out_full = r_out_valid && i_stall;
    assign o_valid = r_out_valid;
    assign o_inverse = r_inverse;
    assign o_no_inverse = r_no_inv;

    // Operand magnitude and sign
    logic            in_neg;
    logic [WIDTH-1:0] in_mag;
    logic [RW-1:0]   mag_w, mod_w;

    assign in_neg = i_value[WIDTH-1];
    assign in_mag = in_neg ? (~i_value + WIDTH'(1)) : i_value;
    assign mag_w = RW'(in_mag);
    assign mod_w = RW'(r_mod);

    // Shifted-subtract step: largest k with rb*2^k <= ra
    logic [2*RW-1:0]      ra_x;
    logic [KW-1:0]        k;
    logic [RW-1:0]        ra_sub;
    logic [COEF_BITS-1:0] ta_sub;
    logic                 sub_lt;
    logic                 more;

    always_comb begin
        ra_x = {{RW{1'b0}}, r_ra};
        k = '0;
        for (int i = 0; i < RW; i++) begin
            if (({{RW{1'b0}}, r_rb} << i) <= ra_x) begin
                k = KW'(i);
            end
        end
        ra_sub = r_ra - (r_rb << k);
        ta_sub = r_ta - (r_tb << k);
        sub_lt = (ra_sub < r_rb);
        more = (r_rb != '0) && (!sub_lt || ra_sub != '0);
    end

    // Result forming
    logic [COEF_BITS-1:0] x_pos, inv_full;
    logic                 none;

    always_comb begin
        x_pos = r_ta[COEF_BITS-1] ? (r_ta + COEF_BITS'(r_mod)) : r_ta;
        inv_full = r_neg ? (COEF_BITS'(r_mod) - x_pos) : x_pos;
        none = (r_ra != RW'(1)) || (r_mod < MOD_MIN);
    end

    // Sequencer: fetch the control word and pick the next address
    always_comb begin
        uw = ucode_rom(r_upc);
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_NO_BEAT:  cond_hit = !in_beat;
            C_MORE:     cond_hit = more;
            C_OUT_FULL: cond_hit = out_full;
            default:    cond_hit = 1'b1;
        endcase
        n_upc = cond_hit ? uw.jump : uw.seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Datapath driven by the control word
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_LOAD: begin
                if (in_beat) begin
                    r_neg <= in_neg;
                    // keep the larger remainder in a
                    if (mag_w > mod_w) begin
                        r_ra <= mag_w;
                        r_ta <= COEF_BITS'(1);
                        r_rb <= mod_w;
                        r_tb <= '0;
                    end else begin
                        r_ra <= mod_w;
                        r_ta <= '0;
                        r_rb <= mag_w;
                        r_tb <= COEF_BITS'(1);
                    end
                end
            end
            OP_STEP: begin
                if (r_rb != '0) begin
                    if (sub_lt) begin
                        r_ra <= r_rb;
                        r_ta <= r_tb;
                        r_rb <= ra_sub;
                        r_tb <= ta_sub;
                    end else begin
                        r_ra <= ra_sub;
                        r_ta <= ta_sub;
                    end
                end
            end
            OP_FINISH: begin
                if (!out_full) begin
                    r_inverse <= none ? '0 : inv_full[MOD_BITS-1:0];
                    r_no_inv <= none;
                end
            end
            default: begin
            end
        endcase
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.op == OP_FINISH && !out_full) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Checks
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_inverse |-> o_inverse == '0)
        else $error("no-inverse beat carries a nonzero value");

    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_no_inverse |-> o_inverse != '0 && o_inverse < r_mod)
        else $error("inverse outside 1..m-1");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc == UA_STEP |-> r_ra >= r_rb)
        else $error("Euclid remainders out of order");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_upc == UA_STEP)
        else $error("accepted beat did not start the loop");

endmodule

// ===== tb/tb_modular_inverse_unit.sv =====
`timescale 1ns / 1ps

module tb_modular_inverse_unit;

    import mi_pkg::*;

    localparam int OP_BITS = 16;
    localparam int STUCK_LIMIT = 6000;
    localparam int END_SETTLE = 120;
    localparam int HOLD_AFTER = 1300;
    localparam int HOLD_CYCLES = 320;
    localparam int CHUNK_ITEMS = 155;
    localparam int NUM_CHUNKS = 10;
    localparam logic [2:0] MODULUS_ADDR = 3'(4 * REG_MODULUS);

    typedef struct {
        logic [OP_BITS-1:0]  operand;
        logic [MOD_BITS-1:0] modulus;
        logic [MOD_BITS-1:0] inverse;
        logic                no_inverse;
    } t_inverse_check;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [OP_BITS-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [MOD_BITS-1:0]       o_inverse;
    logic                      o_no_inverse;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [2:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;

    logic [OP_BITS-1:0]  operand_queue[$];
    t_inverse_check      inverse_expected[$];
    logic [MOD_BITS-1:0] modulus_setting = MOD_RESET;
    int unsigned         send_gap_pct = 37;
    int unsigned         recv_gap_pct = 74;
    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  stuck_cycles = 0;

    modular_inverse_unit #(.WIDTH(OP_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_inverse   (o_inverse),
        .o_no_inverse(o_no_inverse),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Inverse of a signed operand mod m via extended Euclid; the coefficient of |a|,
    // negated mod m for a negative operand, is the inverse when gcd is one
    function automatic t_inverse_check predict_inverse(input logic [OP_BITS-1:0] operand,
                                                       input logic [MOD_BITS-1:0] m);
        t_inverse_check res;
        int unsigned    mag;
        int unsigned    mm;
        int unsigned    r0;
        int unsigned    r1;
        int unsigned    q;
        int unsigned    rem;
        int             t0;
        int             t1;
        int             tn;
        bit             neg;
        neg = operand[OP_BITS-1];
        mag = neg ? (32'h1_0000 - 32'(operand)) : 32'(operand);
        mm = 32'(m);
        res.operand = operand;
        res.modulus = m;
        res.inverse = '0;
        res.no_inverse = 1'b1;
        if (mag == 0 || mm < 2) return res;
        r0 = mm;
        r1 = mag % mm;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            rem = r0 - q * r1;
            r0 = r1;
            r1 = rem;
            tn = t0 - int'(q) * t1;
            t0 = t1;
            t1 = tn;
        end
        // common factor: the search ends on remainder zero
        if (r0 != 1) return res;
        if (t0 < 0) t0 = t0 + int'(mm);
        res.no_inverse = 1'b0;
        res.inverse = neg ? MOD_BITS'(mm - 32'(t0)) : MOD_BITS'(t0);
        return res;
    endfunction

    // Bias operands toward multiples of m, shared factors and extremes
    function automatic logic [OP_BITS-1:0] pick_operand(input int unsigned m);
        int unsigned        kind;
        int unsigned        fac;
        logic [OP_BITS-1:0] v;
        kind = $urandom_range(99);
        if (m < 2 || kind < 40) begin
            v = OP_BITS'($urandom);
        end else if (kind < 58) begin
            v = OP_BITS'($urandom_range(128)) - OP_BITS'(64);
        end else if (kind < 73) begin
            v = OP_BITS'(m * $urandom_range(32767 / m)) + OP_BITS'($urandom_range(2))
                - OP_BITS'(1);
        end else if (kind < 85) begin
            case ($urandom_range(5))
                0: v = 16'h7fff;
                1: v = 16'h8000;
                2: v = 16'h8001;
                3: v = 16'h0000;
                4: v = 16'h0001;
                default: v = 16'hffff;
            endcase
        end else begin
            case ($urandom_range(6))
                0: fac = 2;
                1: fac = 3;
                2: fac = 5;
                3: fac = 7;
                4: fac = 13;
                5: fac = 31;
                default: fac = 151;
            endcase
            v = OP_BITS'(fac * $urandom_range(32767 / fac));
        end
        if (kind >= 58 && kind < 85 && $urandom_range(1)) v = -v;
        if (kind >= 85 && $urandom_range(1)) v = -v;
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic queue_operand(input int v);
        operand_queue.push_back(OP_BITS'(v));
    endtask

    // Block until every queued operand is accepted and answered
    task automatic wait_drained();
        while (operand_queue.size() != 0 || inverse_expected.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the modulus over the config port, then read it back
    task automatic program_modulus(input logic [MOD_BITS-1:0] m);
        logic [31:0] readback;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODULUS_ADDR;
        pwdata <= 32'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        modulus_setting = m;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(m))
            flag_mismatch($sformatf("modulus readback exp %0d got %0d", m, readback));
    endtask

    // Sender: present the next operand when the lane is free, hold while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                inverse_expected.push_back(predict_inverse(i_value, modulus_setting));
            if (!i_valid || !o_stall) begin
                if (operand_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_value <= operand_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Monitor: compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_inverse_check want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_seen <= results_seen + 1;
            if (inverse_expected.size() == 0) begin
                flag_mismatch($sformatf("result with none expected: inverse %0d no_inverse %0b",
                                        o_inverse, o_no_inverse));
            end else begin
                want = inverse_expected.pop_front();
                if (o_inverse !== want.inverse)
                    flag_mismatch($sformatf("a=%0d m=%0d inverse exp %0d got %0d",
                                            $signed(want.operand), want.modulus,
                                            want.inverse, o_inverse));
                if (o_no_inverse !== want.no_inverse)
                    flag_mismatch($sformatf("a=%0d m=%0d no_inverse exp %0b got %0b",
                                            $signed(want.operand), want.modulus,
                                            want.no_inverse, o_no_inverse));
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_modular_inverse_unit: done, errors");
            $finish;
        end
    end

    initial begin
        logic [MOD_BITS-1:0] chunk_mod;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset modulus of two
        queue_operand(0);
        queue_operand(1);
        queue_operand(-1);
        queue_operand(2);
        queue_operand(32767);
        queue_operand(-32768);
        wait_drained();

        // Largest modulus, composite: shared factors and operand extremes
        program_modulus(15'd32767);
        queue_operand(0);
        queue_operand(1);
        queue_operand(-1);
        queue_operand(7);
        queue_operand(-31);
        queue_operand(151);
        queue_operand(32767);
        queue_operand(-32767);
        queue_operand(-32768);
        queue_operand(32766);
        queue_operand(12345);
        queue_operand(2);
        wait_drained();

        // Unusable moduli: zero and one
        program_modulus(15'd0);
        queue_operand(5);
        queue_operand(-5);
        queue_operand(0);
        wait_drained();
        program_modulus(15'd1);
        queue_operand(1);
        queue_operand(-32768);
        queue_operand(0);
        wait_drained();

        // Random chunks, each under its own modulus and one of three gap profiles
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            case (c)
                0: chunk_mod = 15'd32749;
                1: chunk_mod = 15'd2;
                2: chunk_mod = 15'd32767;
                3: chunk_mod = 15'd3;
                4: chunk_mod = 15'd4096;
                6: chunk_mod = 15'd30030;
                8: chunk_mod = 15'd257;
                default: chunk_mod = MOD_BITS'($urandom_range(32767, 2));
            endcase
            if (c < 4) begin
                send_gap_pct = 37;
                recv_gap_pct = 74;
            end else if (c < 7) begin
                send_gap_pct = 74;
                recv_gap_pct = 37;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            program_modulus(chunk_mod);
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                // pause mid-chunk until everything has drained
                if (k == CHUNK_ITEMS / 2) wait_drained();
                operand_queue.push_back(pick_operand(32'(modulus_setting)));
            end
            wait_drained();
        end

        repeat (END_SETTLE) @(posedge i_clk);
        if (inverse_expected.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", inverse_expected.size()));
        if (mismatch_count == 0)
            $display("tb_modular_inverse_unit: done, clean");
        else
            $display("tb_modular_inverse_unit: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mi_pkg.sv
rtl/core/modular_inverse_unit.sv
tb/tb_modular_inverse_unit.sv
